// ===== hw/rtl/mt_pkg.sv =====
// Package for the MT19937 generator: constants, shared types and functions.
// Used by the state RAM, the multiplier unit and the top level.
package mt_pkg;

	localparam int MT_N    = 624;
	localparam int MT_M    = 397;
	localparam int MT_AW   = 10;

	localparam logic [31:0] SEED_BASE  = 32'd19650218;
	localparam logic [31:0] MUL_INIT_C = 32'd1812433253;
	localparam logic [31:0] MUL_KEY_C  = 32'd1664525;
	localparam logic [31:0] MUL_MIX_C  = 32'd1566083941;
	localparam logic [31:0] MATRIX_A   = 32'h9908b0df;
	localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C   = 32'hefc60000;
	localparam logic [31:0] UPPER_MASK = 32'h80000000;

	localparam logic [MT_AW-1:0] LAST_IDX  = MT_AW'(MT_N - 1);
	localparam logic [MT_AW-1:0] FULL_IDX  = MT_AW'(MT_N);
	localparam logic [MT_AW-1:0] WRAP_M    = MT_AW'(MT_N - MT_M);
	localparam logic [MT_AW-1:0] OFFSET_M  = MT_AW'(MT_M);

	localparam logic [1:0] MODE_SEED  = 2'd0;
	localparam logic [1:0] MODE_RAW   = 2'd1;
	localparam logic [1:0] MODE_FRAC  = 2'd2;
	localparam logic [1:0] MODE_BOUND = 2'd3;

	typedef enum logic [1:0] {
		PH_INIT,
		PH_KEY,
		PH_MIX
	} seed_phase_t;

	typedef struct packed {
		logic             we;
		logic [MT_AW-1:0] waddr;
		logic [31:0]      wdata;
		logic [MT_AW-1:0] raddr_a;
		logic [MT_AW-1:0] raddr_b;
	} ram_req_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// 32 minus the bit length of the bound
	function automatic logic [4:0] bound_shift(input logic [30:0] b);
		logic [4:0] sh;
		sh = 5'd0;
		for (int j = 0; j < 31; j++) begin
			if (b[j])
				sh = 5'(31 - j);
		end
		return sh;
	endfunction

endpackage

// ===== hw/rtl/mt_if.sv =====
// Handshake channels for the MT19937 generator: request and result.
// Widths are fixed by the item fields; no dependencies.
interface mt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [30:0] bound;

	modport source (output valid, output mode, output bound, input ready);
	modport sink (input valid, input mode, input bound, output ready);
endinterface

interface mt_res_if;
	logic        valid;
	logic        ready;
	logic [52:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== hw/rtl/mt_state_ram.sv =====
// 624 x 32 twister state memory: one write port, two registered read ports.
// Depends on mt_pkg.
module mt_state_ram (
	input  logic            clk,
	input  mt_pkg::ram_req_t req,
	output logic [31:0]     rd_a,
	output logic [31:0]     rd_b
);
	import mt_pkg::*;

	logic [31:0] mem [MT_N];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		rd_a_q <= mem[req.raddr_a];
		rd_b_q <= mem[req.raddr_b];
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;
endmodule

// ===== hw/rtl/mt_mul_unit.sv =====
// Shared registered 32x32 multiplier (low word) for the seeding passes.
// Depends on mt_pkg for the phase type and constants.
module mt_mul_unit (
	input  logic               clk,
	input  mt_pkg::seed_phase_t phase,
	input  logic [31:0]        operand,
	output logic [31:0]        product
);
	import mt_pkg::*;

	logic [31:0] coef;
	logic [63:0] full;
	logic [31:0] prod_q;

	always_comb begin
		unique case (phase)
			PH_INIT: coef = MUL_INIT_C;
			PH_KEY:  coef = MUL_KEY_C;
			PH_MIX:  coef = MUL_MIX_C;
			default: coef = MUL_INIT_C;
		endcase
	end

	assign full = {32'd0, operand} * {32'd0, coef};

	always_ff @(posedge clk) begin
		prod_q <= full[31:0];
	end

	assign product = prod_q;
endmodule

// ===== hw/rtl/mt19937_random_generator.sv =====
// MT19937 generator top level: sequencer, output register, seed register.
// Depends on mt_pkg, mt_if, mt_state_ram and mt_mul_unit.
//
// A reseed (mode 0) runs the one-word init_by_array over the state RAM with the
// shared multiplier, a multiply state then a write state per step; result value 0.
// A raw draw reads one word; the 53-bit draw takes two words; a bounded draw
// tries words until one is below the bound. When all 624 words are used, the
// next draw first regenerates the state, a registered read then a write for
// each word. The block accepts one request at a time; a finished result sits
// in the output register while the next request is taken. Draws before the
// first reseed return undefined data.
module mt19937_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	mt_req_if.sink      req,
	mt_res_if.source    res
);
	import mt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_WR,
		ST_SEED_FIN,
		ST_DRAW_RD,
		ST_DRAW_USE,
		ST_TW_PRE,
		ST_TW_LD,
		ST_TW_RD,
		ST_TW_WR,
		ST_EMIT
	} state_t;

	state_t           state_q;
	seed_phase_t      phase_q;
	logic [31:0]      seed_q;
	logic [MT_AW-1:0] idx_q;
	logic [MT_AW-1:0] i_q;
	logic [MT_AW-1:0] k_q;
	logic [31:0]      p_q;
	logic [31:0]      cur_q;
	logic [1:0]       mode_q;
	logic [30:0]      bound_q;
	logic [4:0]       sh_q;
	logic             half_q;
	logic [26:0]      hi_q;
	logic [52:0]      res_q;
	logic             out_valid_q;
	logic [52:0]      out_value_q;

	ram_req_t         ram_req;
	logic [31:0]      rd_a;
	logic [31:0]      rd_b;
	logic [31:0]      product;
	logic [31:0]      seed_new;
	logic [31:0]      tw_y;
	logic [31:0]      tw_new;
	logic [31:0]      drawn;
	logic [31:0]      x_cand;
	logic [MT_AW-1:0] i_next;
	logic [MT_AW-1:0] i_wrap;
	logic [MT_AW-1:0] i_far;

	mt_state_ram u_ram (
		.clk  (clk),
		.req  (ram_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	mt_mul_unit u_mul (
		.clk     (clk),
		.phase   (phase_q),
		.operand (p_q ^ (p_q >> 30)),
		.product (product)
	);

	assign i_next = i_q + MT_AW'(1);
	assign i_wrap = (i_q == LAST_IDX) ? MT_AW'(1) : i_next;
	assign i_far  = (i_q < WRAP_M) ? (i_q + OFFSET_M) : (i_q - WRAP_M);

	always_comb begin
		unique case (phase_q)
			PH_INIT: seed_new = product + {22'd0, i_q};
			PH_KEY:  seed_new = (rd_a ^ product) + seed_q;
			PH_MIX:  seed_new = (rd_a ^ product) - {22'd0, i_q};
			default: seed_new = product;
		endcase
	end

	assign tw_y   = {cur_q[31], rd_a[30:0]};
	assign tw_new = rd_b ^ (tw_y >> 1) ^ (tw_y[0] ? MATRIX_A : 32'd0);
	assign drawn  = temper(rd_a);
	assign x_cand = drawn >> sh_q;

	always_comb begin
		ram_req.we      = 1'b0;
		ram_req.waddr   = i_q;
		ram_req.wdata   = seed_new;
		ram_req.raddr_a = i_q;
		ram_req.raddr_b = i_far;
		unique case (state_q)
			ST_SEED_WR: ram_req.we = 1'b1;
			ST_SEED_FIN: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = '0;
				ram_req.wdata = UPPER_MASK;
			end
			ST_DRAW_RD: ram_req.raddr_a = idx_q;
			ST_TW_PRE:  ram_req.raddr_a = '0;
			ST_TW_RD:   ram_req.raddr_a = (i_q == LAST_IDX) ? '0 : i_next;
			ST_TW_WR: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = tw_new;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_INIT;
			seed_q      <= 32'd42;
			idx_q       <= FULL_IDX;
			i_q         <= '0;
			k_q         <= '0;
			p_q         <= '0;
			cur_q       <= '0;
			mode_q      <= MODE_SEED;
			bound_q     <= '0;
			sh_q        <= '0;
			half_q      <= 1'b0;
			hi_q        <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
		end else begin
			if (cfg_wr_en)
				seed_q <= cfg_wr_data;
			if (res.ready && state_q != ST_EMIT)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						mode_q  <= req.mode;
						bound_q <= req.bound;
						sh_q    <= bound_shift(req.bound);
						half_q  <= 1'b0;
						res_q   <= '0;
						if (req.mode == MODE_SEED) begin
							phase_q <= PH_INIT;
							p_q     <= SEED_BASE;
							i_q     <= MT_AW'(1);
							k_q     <= '0;
							state_q <= ST_SEED_MUL;
						end else if (req.mode == MODE_BOUND && req.bound == '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DRAW_RD;
						end
					end
				end
				ST_SEED_MUL: state_q <= ST_SEED_WR;
				ST_SEED_WR: begin
					// key pass starts at word 1, chained from word 0
					p_q     <= (phase_q == PH_INIT && i_q == LAST_IDX) ? SEED_BASE : seed_new;
					state_q <= ST_SEED_MUL;
					unique case (phase_q)
						PH_INIT: begin
							if (i_q == LAST_IDX) begin
								phase_q <= PH_KEY;
								i_q     <= MT_AW'(1);
								k_q     <= '0;
							end else begin
								i_q <= i_next;
							end
						end
						PH_KEY: begin
							i_q <= i_wrap;
							if (k_q == LAST_IDX) begin
								phase_q <= PH_MIX;
								k_q     <= '0;
							end else begin
								k_q <= k_q + MT_AW'(1);
							end
						end
						default: begin
							i_q <= i_wrap;
							k_q <= k_q + MT_AW'(1);
							if (k_q == LAST_IDX - MT_AW'(1))
								state_q <= ST_SEED_FIN;
						end
					endcase
				end
				ST_SEED_FIN: begin
					idx_q   <= FULL_IDX;
					state_q <= ST_EMIT;
				end
				ST_DRAW_RD: begin
					if (idx_q == FULL_IDX) begin
						i_q     <= '0;
						state_q <= ST_TW_PRE;
					end else begin
						idx_q   <= idx_q + MT_AW'(1);
						state_q <= ST_DRAW_USE;
					end
				end
				ST_DRAW_USE: begin
					case (mode_q)
						MODE_RAW: begin
							res_q   <= {21'd0, drawn};
							state_q <= ST_EMIT;
						end
						MODE_FRAC: begin
							if (!half_q) begin
								hi_q    <= drawn[31:5];
								half_q  <= 1'b1;
								state_q <= ST_DRAW_RD;
							end else begin
								res_q   <= {hi_q, drawn[31:6]};
								state_q <= ST_EMIT;
							end
						end
						default: begin
							if (x_cand < {1'b0, bound_q}) begin
								res_q   <= {21'd0, x_cand};
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_DRAW_RD;
							end
						end
					endcase
				end
				ST_TW_PRE: state_q <= ST_TW_LD;
				ST_TW_LD: begin
					cur_q   <= rd_a;
					state_q <= ST_TW_RD;
				end
				ST_TW_RD: state_q <= ST_TW_WR;
				ST_TW_WR: begin
					cur_q <= rd_a;
					if (i_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_DRAW_RD;
					end else begin
						i_q     <= i_next;
						state_q <= ST_TW_RD;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign res.valid = out_valid_q;
	assign res.value = out_value_q;
endmodule

// ===== verif/mt_draw_checker.sv =====
// Checker for the MT19937 generator: watches the request, result and seed write
// ports, predicts each drawn value and compares it. Depends on mt_pkg and mt_if.
`timescale 1ns / 1ps
module mt_draw_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	mt_req_if           req,
	mt_res_if           res,
	output int          mismatches,
	output int          pending,
	output int          twists,
	output int          checked
);
	import mt_pkg::*;

	localparam logic [31:0] SEED_AT_RESET = 32'd42;
	localparam int          MAX_PRINTED   = 40;

	logic [31:0] mt_words [0:MT_N-1];
	int unsigned word_pos;
	logic [31:0] seed_key;
	logic [52:0] expected_values [$];

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// one-word init_by_array
	function automatic void reseed(input logic [31:0] key);
		int unsigned i;
		logic [31:0] p;
		mt_words[0] = SEED_BASE;
		for (int n = 1; n < MT_N; n++) begin
			p = mt_words[n-1];
			mt_words[n] = MUL_INIT_C * (p ^ (p >> 30)) + 32'(n);
		end
		i = 1;
		for (int n = 0; n < MT_N; n++) begin
			p = mt_words[i-1];
			mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * MUL_KEY_C)) + key;
			i++;
			if (i >= MT_N) begin
				mt_words[0] = mt_words[MT_N-1];
				i = 1;
			end
		end
		for (int n = 0; n < MT_N - 1; n++) begin
			p = mt_words[i-1];
			mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * MUL_MIX_C)) - i;
			i++;
			if (i >= MT_N) begin
				mt_words[0] = mt_words[MT_N-1];
				i = 1;
			end
		end
		mt_words[0] = UPPER_MASK;
		word_pos = MT_N;
		twists = 0;
	endfunction

	// in place, so late entries see already regenerated neighbors
	function automatic void regenerate();
		logic [31:0] y;
		for (int n = 0; n < MT_N; n++) begin
			y = (mt_words[n] & UPPER_MASK) | (mt_words[(n + 1) % MT_N] & ~UPPER_MASK);
			mt_words[n] = mt_words[(n + MT_M) % MT_N] ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
		end
		word_pos = 0;
		twists++;
	endfunction

	function automatic logic [31:0] next_word();
		logic [31:0] y;
		if (word_pos >= MT_N)
			regenerate();
		y = mt_words[word_pos];
		word_pos++;
		y ^= y >> 11;
		y ^= (y << 7) & TEMPER_B;
		y ^= (y << 15) & TEMPER_C;
		y ^= y >> 18;
		return y;
	endfunction

	function automatic logic [52:0] predict_draw(input logic [1:0] m, input logic [30:0] b);
		logic [31:0] hi, lo, x;
		int          nbits;
		case (m)
			MODE_SEED: begin
				reseed(seed_key);
				return '0;
			end
			MODE_RAW:
				return 53'(next_word());
			MODE_FRAC: begin
				hi = next_word();
				lo = next_word();
				return {hi[31:5], lo[31:6]};
			end
			default: begin
				if (b == '0)
					return '0;
				nbits = 0;
				for (int j = 0; j < 31; j++)
					if (b[j])
						nbits = j + 1;
				do begin
					x = next_word() >> (32 - nbits);
				end while (x >= {1'b0, b});
				return 53'(x);
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [52:0] want;
		if (!arst_n) begin
			for (int n = 0; n < MT_N; n++)
				mt_words[n] = '0;
			word_pos = MT_N;
			seed_key = SEED_AT_RESET;
			expected_values.delete();
			mismatches = 0;
			pending = 0;
			twists = 0;
			checked = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_values.size() == 0) begin
					report_mismatch($sformatf("result 0x%014h with no request waiting",
						res.value));
				end else begin
					want = expected_values.pop_front();
					checked++;
					if (res.value !== want)
						report_mismatch($sformatf("value 0x%014h, expected 0x%014h",
							res.value, want));
				end
			end
			if (req.valid && req.ready)
				expected_values.push_back(predict_draw(req.mode, req.bound));
			if (cfg_wr_en)
				seed_key = cfg_wr_data;
			pending = expected_values.size();
		end
	end

endmodule

// ===== verif/tb_mt19937_random_generator.sv =====
// Testbench top for the MT19937 generator: clock, reset, seed writes, request
// stimulus and result back-pressure. Depends on mt_pkg, mt_if, mt_draw_checker, mt19937_random_generator.
`timescale 1ns / 1ps
module tb_mt19937_random_generator;
	import mt_pkg::*;

	localparam int ITEMS_PER_PHASE = 160;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	int          fail_count, pending, twists, checked;
	int          send_idle_pct, recv_idle_pct, stall_left;
	int          n_seed, n_raw, n_frac, n_bound;

	mt_req_if req_ch ();
	mt_res_if res_ch ();

	mt19937_random_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_ch),
		.res        (res_ch)
	);

	mt_draw_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_ch),
		.res        (res_ch),
		.mismatches (fail_count),
		.pending    (pending),
		.twists     (twists),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("timeout with %0d results outstanding", pending);
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: random back-pressure, plus one long hold-off when stall_left is set
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_item(input logic [1:0] m, input logic [30:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.mode  <= 2'($urandom);
			req_ch.bound <= 31'($urandom);
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode  <= m;
		req_ch.bound <= b;
		case (m)
			MODE_SEED:  n_seed++;
			MODE_RAW:   n_raw++;
			MODE_FRAC:  n_frac++;
			MODE_BOUND: n_bound++;
		endcase
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (5) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] s);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= s;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [30:0] pick_bound();
		int unsigned r, k;
		r = $urandom_range(99);
		if (r < 3)
			return '0;
		if (r < 10)
			return '1;
		if (r < 35)
			return 31'($urandom_range(16, 1));
		k = $urandom_range(31, 1);
		return 31'(($urandom & ((32'd1 << (k - 1)) - 1)) | (32'd1 << (k - 1)));
	endfunction

	// reseed only after the state has been refilled twice since the last reseed, so runs reach the refill
	task automatic random_item();
		int unsigned r;
		logic [1:0]  m;
		r = $urandom_range(99);
		if (twists >= 2 && r < 4)
			m = MODE_SEED;
		else if (r < 28)
			m = MODE_RAW;
		else if (r < 70)
			m = MODE_FRAC;
		else
			m = MODE_BOUND;
		send_item(m, (m == MODE_BOUND) ? pick_bound() : 31'($urandom));
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		req_ch.valid  = 1'b0;
		req_ch.mode   = MODE_SEED;
		req_ch.bound  = '0;
		send_idle_pct = 6;
		recv_idle_pct = 68;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_seed(32'h0000_0000);
		send_item(MODE_SEED, '1);
		send_item(MODE_RAW, '0);
		send_item(MODE_FRAC, '1);
		send_item(MODE_BOUND, '0);
		send_item(MODE_BOUND, 31'd1);
		send_item(MODE_BOUND, 31'd2);
		send_item(MODE_BOUND, 31'd3);
		send_item(MODE_BOUND, '1);
		send_item(MODE_BOUND, 31'h4000_0000);
		send_item(MODE_BOUND, 31'h4000_0001);
		send_item(MODE_BOUND, 31'h2aaa_aaaa);
		send_item(MODE_BOUND, 31'h5555_5555);
		send_item(MODE_RAW, '1);
		drain_results();
		write_seed(32'hffff_ffff);
		send_item(MODE_SEED, '0);
		send_item(MODE_FRAC, '0);
		send_item(MODE_RAW, 31'h5555_5555);
		send_item(MODE_BOUND, 31'd1000);

		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				drain_results();
				send_idle_pct = 68;
				recv_idle_pct = 6;
				write_seed($urandom);
			end
			if (ph == 2) begin
				drain_results();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				write_seed(32'd42);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 0 && n == 40)
					stall_left = 300;
				if (ph == 0 && n == 100)
					drain_results();
				random_item();
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		$display("Sent %0d requests: %0d reseeds, %0d raw, %0d fraction, %0d bounded; %0d compared.",
			n_seed + n_raw + n_frac + n_bound, n_seed, n_raw, n_frac, n_bound, checked);
		$display("Seeds zero, all-ones, random and power-on; three throttle profiles, long stall.");
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
